// File: hw/rtl/sll_pkg.sv
package sll_pkg;

    // token kinds
    localparam logic [5:0] K_LBRACE = 6'd0;
    localparam logic [5:0] K_RBRACE = 6'd1;
    localparam logic [5:0] K_LPAREN = 6'd2;
    localparam logic [5:0] K_RPAREN = 6'd3;
    localparam logic [5:0] K_SEMI   = 6'd4;
    localparam logic [5:0] K_AND1   = 6'd5;
    localparam logic [5:0] K_AND2   = 6'd6;
    localparam logic [5:0] K_OR1    = 6'd7;
    localparam logic [5:0] K_OR2    = 6'd8;
    localparam logic [5:0] K_NOT    = 6'd9;
    localparam logic [5:0] K_GT     = 6'd10;
    localparam logic [5:0] K_LT     = 6'd11;
    localparam logic [5:0] K_NE     = 6'd12;
    localparam logic [5:0] K_LE     = 6'd13;
    localparam logic [5:0] K_GE     = 6'd14;
    localparam logic [5:0] K_ASSIGN = 6'd15;
    localparam logic [5:0] K_EQ     = 6'd16;
    localparam logic [5:0] K_PLUS   = 6'd17;
    localparam logic [5:0] K_MINUS  = 6'd18;
    localparam logic [5:0] K_MUL    = 6'd19;
    localparam logic [5:0] K_DIV    = 6'd20;
    localparam logic [5:0] K_MOD    = 6'd21;
    localparam logic [5:0] K_CONST  = 6'd22;
    localparam logic [5:0] K_IDENT  = 6'd23;
    localparam logic [5:0] K_PROCEDURE = 6'd24;
    localparam logic [5:0] K_READ      = 6'd25;
    localparam logic [5:0] K_PRINT     = 6'd26;
    localparam logic [5:0] K_CALL      = 6'd27;
    localparam logic [5:0] K_IF        = 6'd28;
    localparam logic [5:0] K_WHILE     = 6'd29;
    localparam logic [5:0] K_THEN      = 6'd30;
    localparam logic [5:0] K_ELSE      = 6'd31;
    localparam logic [5:0] K_END    = 6'd32;
    localparam logic [5:0] K_ERROR  = 6'd33;
    localparam logic [5:0] K_NONE   = 6'd63;

    // parameter defaults
    localparam int KW_MAX_CHARS_DEF = 9;
    localparam int OFFSET_BITS_DEF  = 16;

    // keyword table
    localparam int KW_COUNT     = 8;
    localparam int KW_CMP_CHARS = 9;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CMP_CHARS] = '{
        '{"p", "r", "o", "c", "e", "d", "u", "r", "e"},
        '{"r", "e", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "a", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [7:0] KW_LEN  [KW_COUNT] = '{
        8'd9, 8'd4, 8'd5, 8'd4, 8'd2, 8'd5, 8'd4, 8'd4
    };
    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        K_PROCEDURE, K_READ, K_PRINT, K_CALL, K_IF, K_WHILE, K_THEN, K_ELSE
    };

    // output queue
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);
    localparam int MAX_RES   = 3;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SINGLE,
        ACT_BEGIN,
        ACT_EXTEND,
        ACT_COMBINE,
        ACT_ERROR
    } t_act;

    typedef struct packed {
        logic       last;
        logic [7:0] length;
        logic [15:0] start;
        logic [5:0] kind;
    } t_tok;

    typedef struct packed {
        logic [1:0]        count;
        t_tok [MAX_RES-1:0] tok;
    } t_step_res;

    function automatic t_tok mk_tok(input logic [5:0] kind, input logic [15:0] start,
                                    input logic [7:0] length);
        t_tok t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.last   = 1'b0;
        return t;
    endfunction

    // identifier text -> keyword kind, or K_IDENT
    function automatic logic [5:0] kw_classify(input logic [KW_CMP_CHARS-1:0][7:0] c,
                                               input logic [7:0] len);
        logic [5:0] k;
        logic       hit;
        k = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            hit = (len == KW_LEN[i]);
            for (int j = 0; j < KW_CMP_CHARS; j++) begin
                if (8'(j) < KW_LEN[i] && c[j] != KW_TEXT[i][j]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                k = KW_KIND[i];
            end
        end
        return k;
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

// File: hw/rtl/sll_lex_core.sv
module sll_lex_core
    import sll_pkg::*;
#(
    parameter int KW_MAX_CHARS = KW_MAX_CHARS_DEF,
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  logic [7:0] i_char,
    input  logic      i_eos,
    output t_step_res o_res
);

    localparam int KW_IDX_W = $clog2(KW_MAX_CHARS);

    logic [5:0]             r_pk, n_pk;
    logic [OFFSET_BITS-1:0] r_ps, n_ps;
    logic [7:0]             r_pl, n_pl;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic                   r_err, n_err;
    logic [7:0]             r_kw [KW_MAX_CHARS];
    logic [7:0]             n_kw [KW_MAX_CHARS];
    t_step_res              n_res;

    // character decode
    t_act       w_act;
    logic       w_flush;
    logic [5:0] w_akind;

    always_comb begin
        w_act   = ACT_NONE;
        w_flush = 1'b0;
        w_akind = K_NONE;
        case (i_char)
            "{": begin w_flush = 1'b1; w_act = ACT_SINGLE; w_akind = K_LBRACE; end
            "}": begin w_flush = 1'b1; w_act = ACT_SINGLE; w_akind = K_RBRACE; end
            "(": begin w_flush = 1'b1; w_act = ACT_SINGLE; w_akind = K_LPAREN; end
            ")": begin w_flush = 1'b1; w_act = ACT_SINGLE; w_akind = K_RPAREN; end
            ";": begin w_flush = 1'b1; w_act = ACT_SINGLE; w_akind = K_SEMI; end
            "+": begin w_flush = 1'b1; w_act = ACT_SINGLE; w_akind = K_PLUS; end
            "-": begin w_flush = 1'b1; w_act = ACT_SINGLE; w_akind = K_MINUS; end
            "*": begin w_flush = 1'b1; w_act = ACT_SINGLE; w_akind = K_MUL; end
            "/": begin w_flush = 1'b1; w_act = ACT_SINGLE; w_akind = K_DIV; end
            "%": begin w_flush = 1'b1; w_act = ACT_SINGLE; w_akind = K_MOD; end
            " ", 8'h09: begin
                w_flush = 1'b1;
            end
            "&": begin
                if (r_pk == K_AND1) begin
                    w_act = ACT_COMBINE; w_akind = K_AND2;
                end else begin
                    w_flush = 1'b1; w_act = ACT_BEGIN; w_akind = K_AND1;
                end
            end
            "|": begin
                if (r_pk == K_OR1) begin
                    w_act = ACT_COMBINE; w_akind = K_OR2;
                end else begin
                    w_flush = 1'b1; w_act = ACT_BEGIN; w_akind = K_OR1;
                end
            end
            "!": begin w_flush = 1'b1; w_act = ACT_BEGIN; w_akind = K_NOT; end
            ">": begin w_flush = 1'b1; w_act = ACT_BEGIN; w_akind = K_GT; end
            "<": begin w_flush = 1'b1; w_act = ACT_BEGIN; w_akind = K_LT; end
            "=": begin
                w_act = ACT_COMBINE;
                if (r_pk == K_NOT) begin
                    w_akind = K_NE;
                end else if (r_pk == K_LT) begin
                    w_akind = K_LE;
                end else if (r_pk == K_GT) begin
                    w_akind = K_GE;
                end else if (r_pk == K_ASSIGN) begin
                    w_akind = K_EQ;
                end else begin
                    w_flush = 1'b1; w_act = ACT_BEGIN; w_akind = K_ASSIGN;
                end
            end
            default: begin
                if (i_char inside {["0":"9"]}) begin
                    if (r_pk == K_IDENT || r_pk == K_CONST) begin
                        w_act = ACT_EXTEND;
                    end else begin
                        w_flush = 1'b1; w_act = ACT_BEGIN; w_akind = K_CONST;
                    end
                end else if (i_char inside {["A":"Z"], ["a":"z"]}) begin
                    if (r_pk == K_IDENT) begin
                        w_act = ACT_EXTEND;
                    end else begin
                        w_flush = 1'b1; w_act = ACT_BEGIN; w_akind = K_IDENT;
                    end
                end else begin
                    w_act = ACT_ERROR;
                end
            end
        endcase
    end

    // one character step
    always_comb begin
        logic [KW_CMP_CHARS-1:0][7:0] v_cur;
        logic [KW_CMP_CHARS-1:0][7:0] v_nxt;
        logic [1:0]                   v_n;
        logic [5:0]                   v_kind;

        for (int j = 0; j < KW_CMP_CHARS; j++) begin
            v_cur[j] = r_kw[j];
        end

        n_pk   = r_pk;
        n_ps   = r_ps;
        n_pl   = r_pl;
        n_err  = r_err;
        n_kw   = r_kw;
        n_res  = '0;
        v_n    = 2'd0;
        v_kind = K_NONE;

        if (!r_err) begin
            if (w_flush && r_pk != K_NONE) begin
                v_kind = (r_pk == K_IDENT) ? kw_classify(v_cur, r_pl) : r_pk;
                n_res.tok[v_n] = mk_tok(v_kind, 16'(r_ps), r_pl);
                v_n = v_n + 2'd1;
            end
            if (w_flush) begin
                n_pk = K_NONE;
                n_pl = 8'd0;
            end
            case (w_act)
                ACT_SINGLE: begin
                    n_res.tok[v_n] = mk_tok(w_akind, 16'(r_off), 8'd1);
                    v_n = v_n + 2'd1;
                end
                ACT_BEGIN: begin
                    n_pk    = w_akind;
                    n_ps    = r_off;
                    n_pl    = 8'd1;
                    n_kw[0] = i_char;
                end
                ACT_EXTEND: begin
                    if (r_pl < 8'(KW_MAX_CHARS)) begin
                        n_kw[r_pl[KW_IDX_W-1:0]] = i_char;
                    end
                    n_pl = sat_inc(r_pl);
                end
                ACT_COMBINE: begin
                    n_res.tok[v_n] = mk_tok(w_akind, 16'(r_ps), sat_inc(r_pl));
                    v_n  = v_n + 2'd1;
                    n_pk = K_NONE;
                    n_pl = 8'd0;
                end
                ACT_ERROR: begin
                    n_res.tok[v_n] = mk_tok(K_ERROR, 16'(r_off), 8'd1);
                    v_n   = v_n + 2'd1;
                    n_pk  = K_NONE;
                    n_pl  = 8'd0;
                    n_err = 1'b1;
                end
                default: begin
                end
            endcase
        end

        for (int j = 0; j < KW_CMP_CHARS; j++) begin
            v_nxt[j] = n_kw[j];
        end

        if (i_eos) begin
            if (n_pk != K_NONE) begin
                v_kind = (n_pk == K_IDENT) ? kw_classify(v_nxt, n_pl) : n_pk;
                n_res.tok[v_n] = mk_tok(v_kind, 16'(n_ps), n_pl);
                v_n = v_n + 2'd1;
            end
            n_off = r_off + 1'b1;
            n_res.tok[v_n] = mk_tok(K_END, 16'(n_off), 8'd0);
            v_n   = v_n + 2'd1;
            // back to a fresh source
            n_pk  = K_NONE;
            n_ps  = '0;
            n_pl  = 8'd0;
            n_off = '0;
            n_err = 1'b0;
        end else begin
            n_off = r_off + 1'b1;
        end

        n_res.count = v_n;
        for (int i = 0; i < MAX_RES; i++) begin
            n_res.tok[i].last = (v_n != 2'd0) && (2'(i) == v_n - 2'd1);
        end
    end

    assign o_res = n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk  <= K_NONE;
            r_ps  <= '0;
            r_pl  <= 8'd0;
            r_off <= '0;
            r_err <= 1'b0;
        end else if (i_step) begin
            r_pk  <= n_pk;
            r_ps  <= n_ps;
            r_pl  <= n_pl;
            r_off <= n_off;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_kw <= n_kw;
        end
    end

endmodule

// File: hw/rtl/sll_out_queue.sv
module sll_out_queue
    import sll_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_step_res i_res,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_tok      o_tok
);

    t_tok             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [Q_CW-1:0]  r_cnt;
    logic [Q_CW-1:0]  n_cnt;
    logic             w_pop;
    logic [Q_CW-1:0]  w_add;

    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign o_room  = (r_cnt <= Q_CW'(Q_DEPTH - MAX_RES));
    assign w_pop   = o_valid && i_ready;
    assign w_add   = i_push ? Q_CW'(i_res.count) : '0;
    assign n_cnt   = r_cnt + w_add - Q_CW'(w_pop);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (i_push && 2'(i) < i_res.count) begin
                r_mem[r_wr + Q_AW'(i)] <= i_res.tok[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + Q_AW'(w_add);
            r_rd  <= r_rd + Q_AW'(w_pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: hw/rtl/simple_language_lexer_unit.sv
// Lexer: one source character per transaction, tokens out as (kind, start, length).
// Path: a character is held in the input register until the queue has room, then its
//   tokens are written into the output queue, from which m_axis presents them.
// Throughput: one character per cycle while each character yields at most one token
//   and the receiver is ready; a character giving more tokens can stall input.
// Reset: synchronous, active low; clears lexer state and the queue. No clearing pass.
module simple_language_lexer_unit
    import sll_pkg::*;
#(
    parameter int KW_MAX_CHARS = KW_MAX_CHARS_DEF,
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input characters
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_source
    // output tokens
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] token_kind, [21:6] token_start,
                                        // [29:22] token_length, [31:30] zero
    output logic        m_axis_tlast    // last_of_run
);

    // input register stage
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eos;

    logic       w_room;
    logic       w_step;
    logic       w_take;
    t_step_res  w_res;
    t_tok       w_tok;

    // The step runs once the queue has space for the worst case of three tokens,
    // so the core never needs to hold a half-delivered character. The queue counts
    // as having space while it holds at most one token.
    assign w_step        = r_in_valid && w_room;
    assign s_axis_tready = !r_in_valid || w_room;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_char <= s_axis_tdata;
            r_eos  <= s_axis_tlast;
        end
    end

    // tokenizer state and combinational step logic
    sll_lex_core #(
        .KW_MAX_CHARS (KW_MAX_CHARS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_char  (r_char),
        .i_eos   (r_eos),
        .o_res   (w_res)
    );

    // result queue: takes up to three tokens per step, hands out one per cycle while the receiver is ready
    sll_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_step),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (w_tok)
    );

    assign m_axis_tdata = {2'b00, w_tok.length, w_tok.start, w_tok.kind};
    assign m_axis_tlast = w_tok.last;

endmodule

// File: hw/rtl/sll_checker.sv
module sll_checker
    import sll_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled character holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("stalled character changed");

    // a stalled token holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled token changed");

    // end marker is empty and closes the run
    a_end_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5:0] == K_END |->
            m_axis_tdata[29:22] == 8'd0 && m_axis_tlast)
        else $error("malformed end marker");

    // error token covers one character
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5:0] == K_ERROR |-> m_axis_tdata[29:22] == 8'd1)
        else $error("error token length not one");

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("token valid after reset");

endmodule

bind simple_language_lexer_unit sll_checker u_sll_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: bench/simple_language_lexer_unit_test.sv
`timescale 1ns / 100ps

module simple_language_lexer_unit_test;
    import sll_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 4;
    localparam int IDLE_PCT        = 28;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_CHARS    = 80;
    localparam int DRAIN_CYCLES    = 12;
    localparam int KW_CHARS        = 9;

    typedef struct {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [7:0]  length;
        logic        last;
    } t_token;

    // one directed character; typed rows carry the single token they must give
    typedef struct {
        logic [7:0]  ch;
        logic        eos;
        logic        typed;
        logic [5:0]  kind;
        logic [15:0] start;
        logic [7:0]  length;
    } t_char_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_code
    logic        s_axis_tlast;   // end_of_source
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [5:0] kind, [21:6] start, [29:22] length, [31:30] zero
    logic        m_axis_tlast;   // last token of the character

    simple_language_lexer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    string kw_text [8] = '{"procedure", "read", "print", "call", "if", "while", "then", "else"};
    logic [5:0] kw_kind [8] = '{K_PROCEDURE, K_READ, K_PRINT, K_CALL,
                                K_IF, K_WHILE, K_THEN, K_ELSE};
    string sym_text = "{}();+-*/%";
    string op_text [15] = '{"&", "&&", "&&&", "|", "||", "|||", "!", "!=",
                            "<", "<=", ">", ">=", "=", "==", "==="};

    // Directed source: every single symbol (typed), operator pairs and
    // repeats, constant then identifier with a digit, tab, an unknown byte
    // (0xFF), a byte ignored after the error (0x00), then newline as the
    // last character, which only closes the source with the end marker.
    t_char_row dir_rows [32] = '{
        '{"{",   1'b0, 1'b1, K_LBRACE, 16'd0,  8'd1},
        '{"}",   1'b0, 1'b1, K_RBRACE, 16'd1,  8'd1},
        '{"(",   1'b0, 1'b1, K_LPAREN, 16'd2,  8'd1},
        '{")",   1'b0, 1'b1, K_RPAREN, 16'd3,  8'd1},
        '{";",   1'b0, 1'b1, K_SEMI,   16'd4,  8'd1},
        '{"+",   1'b0, 1'b1, K_PLUS,   16'd5,  8'd1},
        '{"-",   1'b0, 1'b1, K_MINUS,  16'd6,  8'd1},
        '{"*",   1'b0, 1'b1, K_MUL,    16'd7,  8'd1},
        '{"/",   1'b0, 1'b1, K_DIV,    16'd8,  8'd1},
        '{"%",   1'b0, 1'b1, K_MOD,    16'd9,  8'd1},
        '{"&",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"&",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"&",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"|",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"|",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"!",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"=",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"<",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"=",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{">",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{">",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"=",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"=",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"=",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"=",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"7",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"k",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"3",   1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"\t",  1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{8'hFF, 1'b0, 1'b1, K_ERROR,  16'd29, 8'd1},
        '{8'h00, 1'b0, 1'b0, K_NONE,   16'd0,  8'd0},
        '{"\n",  1'b1, 1'b1, K_END,    16'd32, 8'd0}
    };

    // ------------------------------------------------------------------
    // Token predictor: own copy of the lexer state
    // ------------------------------------------------------------------
    logic [5:0]  lx_kind;               // pending token kind, K_NONE if none
    logic [15:0] lx_start;
    logic [7:0]  lx_len;
    logic [7:0]  lx_chars [KW_CHARS];   // leading chars of the pending token
    logic [15:0] lx_pos;                // offset of the current character
    bit          lx_halted;             // unknown byte seen, wait for end of source

    t_token      step_tokens [$];       // tokens of the character just lexed
    t_token      awaited_tokens [$];    // tokens the block still owes
    logic [7:0]  src_chars [$];         // source text being assembled
    t_token      no_tok;

    int fail_count = 0;
    int live_chars = 0;                 // accepted characters that were lexed
    bit calm = 1'b0;                    // both sides stop idling while set
    int hold_asks = 0;

    function void lexer_clear();
        lx_kind   = K_NONE;
        lx_start  = '0;
        lx_len    = '0;
        foreach (lx_chars[i]) lx_chars[i] = '0;
        lx_pos    = '0;
        lx_halted = 1'b0;
    endfunction

    function void put_token(logic [5:0] kind, logic [15:0] start, logic [7:0] length);
        t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.last   = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    // emit the pending token; identifiers matching a keyword take its kind
    function void flush_token();
        logic [5:0] k;
        bit         hit;
        if (lx_kind != K_NONE) begin
            k = lx_kind;
            if (k == K_IDENT) begin
                for (int i = 0; i < 8; i++) begin
                    if (int'(lx_len) == kw_text[i].len()) begin
                        hit = 1'b1;
                        for (int j = 0; j < kw_text[i].len(); j++) begin
                            if (lx_chars[j] != kw_text[i][j]) hit = 1'b0;
                        end
                        if (hit) k = kw_kind[i];
                    end
                end
            end
            put_token(k, lx_start, lx_len);
        end
        lx_kind = K_NONE;
        lx_len  = '0;
    endfunction

    function void grow_token(logic [7:0] c);
        if (lx_len < KW_CHARS) lx_chars[lx_len[3:0]] = c;
        if (lx_len != 8'hFF) lx_len = lx_len + 8'd1;
    endfunction

    function void open_token(logic [5:0] kind, logic [7:0] c);
        lx_kind  = kind;
        lx_start = lx_pos;
        lx_len   = '0;
        grow_token(c);
    endfunction

    // '&' and '|': second of a pair completes it, otherwise starts a new one
    function void pair_or_open(logic [5:0] first, logic [5:0] second, logic [7:0] c);
        if (lx_kind == first) begin
            lx_kind = second;
            grow_token(c);
            flush_token();
        end else begin
            flush_token();
            open_token(first, c);
        end
    endfunction

    function void lex_char(logic [7:0] c, logic eos);
        logic [5:0] sk;
        step_tokens.delete();
        if (!lx_halted) begin
            sk = K_NONE;
            case (c)
                "{": sk = K_LBRACE;
                "}": sk = K_RBRACE;
                "(": sk = K_LPAREN;
                ")": sk = K_RPAREN;
                ";": sk = K_SEMI;
                "+": sk = K_PLUS;
                "-": sk = K_MINUS;
                "*": sk = K_MUL;
                "/": sk = K_DIV;
                "%": sk = K_MOD;
                default: sk = K_NONE;
            endcase
            if (sk != K_NONE) begin
                flush_token();
                put_token(sk, lx_pos, 8'd1);
            end else begin
                case (c)
                    " ", "\t": flush_token();
                    "&": pair_or_open(K_AND1, K_AND2, c);
                    "|": pair_or_open(K_OR1, K_OR2, c);
                    "!": begin
                        flush_token();
                        open_token(K_NOT, c);
                    end
                    ">": begin
                        flush_token();
                        open_token(K_GT, c);
                    end
                    "<": begin
                        flush_token();
                        open_token(K_LT, c);
                    end
                    "=": begin
                        if (lx_kind == K_NOT || lx_kind == K_LT ||
                            lx_kind == K_GT || lx_kind == K_ASSIGN) begin
                            lx_kind = (lx_kind == K_NOT) ? K_NE :
                                      (lx_kind == K_LT)  ? K_LE :
                                      (lx_kind == K_GT)  ? K_GE : K_EQ;
                            grow_token(c);
                            flush_token();
                        end else begin
                            flush_token();
                            open_token(K_ASSIGN, c);
                        end
                    end
                    default: begin
                        if (c inside {["0":"9"]}) begin
                            if (lx_kind == K_ASSIGN) flush_token();
                            if (lx_kind == K_IDENT || lx_kind == K_CONST) begin
                                grow_token(c);
                            end else begin
                                flush_token();
                                open_token(K_CONST, c);
                            end
                        end else if (c inside {["A":"Z"], ["a":"z"]}) begin
                            if (lx_kind == K_IDENT) begin
                                grow_token(c);
                            end else begin
                                flush_token();
                                open_token(K_IDENT, c);
                            end
                        end else begin
                            // unknown byte: drop pending token, report, go quiet
                            lx_kind = K_NONE;
                            lx_len  = '0;
                            put_token(K_ERROR, lx_pos, 8'd1);
                            lx_halted = 1'b1;
                        end
                    end
                endcase
            end
        end
        if (eos) begin
            flush_token();
            put_token(K_END, lx_pos + 16'd1, 8'd0);
            lexer_clear();
        end else begin
            lx_pos = lx_pos + 16'd1;
        end
        if (step_tokens.size() > 0) begin
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Source text generation
    // ------------------------------------------------------------------
    function void add_char(logic [7:0] c);
        src_chars.insert(src_chars.size(), c);
    endfunction

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endfunction

    function logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(61);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return 8'("0" + r - 52);
    endfunction

    // mostly well-formed lexemes glued with or without separators,
    // plus the odd arbitrary byte
    function void add_piece();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            add_text(kw_text[$urandom_range(7)]);
            if ($urandom_range(9) == 0) add_char(rand_alnum());
            else if ($urandom_range(9) == 0) void'(src_chars.pop_back());
        end else if (pick < 30) begin
            add_char(($urandom_range(1)) ? 8'("a" + $urandom_range(25))
                                         : 8'("A" + $urandom_range(25)));
            repeat ($urandom_range(6)) add_char(rand_alnum());
        end else if (pick < 40) begin
            repeat ($urandom_range(5, 1)) add_char(8'("0" + $urandom_range(9)));
        end else if (pick < 55) begin
            add_char(sym_text[$urandom_range(9)]);
        end else if (pick < 75) begin
            add_text(op_text[$urandom_range(14)]);
        end else if (pick < 95) begin
            repeat ($urandom_range(2, 1)) add_text(($urandom_range(1)) ? " " : "\t");
        end else begin
            add_char(8'($urandom_range(255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: one character per transaction, driven at the falling edge
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic eos,
                             input logic use_typed, input t_token typed_tok);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tlast  = eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (!lx_halted) live_chars++;
        lex_char(c, eos);
        if (use_typed) begin
            step_tokens.delete();
            step_tokens.insert(0, typed_tok);
        end
        foreach (step_tokens[i]) awaited_tokens.insert(awaited_tokens.size(), step_tokens[i]);
        @(negedge i_clk);
    endtask

    // whole assembled source, end of source flagged on its last character
    task automatic send_source();
        foreach (src_chars[i]) send_char(src_chars[i], i == src_chars.size() - 1, 1'b0, no_tok);
        src_chars.delete();
    endtask

    task automatic wait_drained();
        while (awaited_tokens.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // each token transaction against the oldest awaited token
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_tokens.size() == 0) begin
                $error("unexpected token: kind %0d start %0d length %0d",
                       m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tdata[29:22]);
                fail_count++;
            end else begin
                want = awaited_tokens.pop_front();
                if (m_axis_tdata[5:0] != want.kind) begin
                    $error("token_kind: expected %0d, actual %0d", want.kind, m_axis_tdata[5:0]);
                    fail_count++;
                end
                if (m_axis_tdata[21:6] != want.start) begin
                    $error("token_start: expected %0d, actual %0d",
                           want.start, m_axis_tdata[21:6]);
                    fail_count++;
                end
                if (m_axis_tdata[29:22] != want.length) begin
                    $error("token_length: expected %0d, actual %0d",
                           want.length, m_axis_tdata[29:22]);
                    fail_count++;
                end
                if (m_axis_tlast != want.last) begin
                    $error("last_of_run: expected %0d, actual %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_token tok;
        int     base;
        int     src_count;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        no_tok        = '{K_NONE, 16'd0, 8'd0, 1'b0};
        lexer_clear();
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            tok = '{dir_rows[i].kind, dir_rows[i].start, dir_rows[i].length, 1'b1};
            send_char(dir_rows[i].ch, dir_rows[i].eos, dir_rows[i].typed, tok);
        end
        s_axis_tvalid = 1'b0;
        wait_drained();

        // near-keywords, case sensitivity, identifiers longer than any keyword
        add_text("procedures iff whil ELSE procedure9 x ;");
        send_source();

        // receiver holds off while a burst of mostly one-token characters piles up
        hold_asks++;
        add_text("{}();+-*/%{}()x");
        send_source();

        base = live_chars;
        src_count = 0;
        while (live_chars - base < RANDOM_CHARS || src_count < 7) begin
            calm = (src_count >= 2 && src_count < 5);
            repeat ($urandom_range(4, 1)) add_piece();
            if (src_count == 6) begin
                s_axis_tvalid = 1'b0;
                wait_drained();
            end
            send_source();
            src_count++;
        end
        calm = 1'b0;

        s_axis_tvalid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
